FILE: rtl/core/lmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmf_pkg;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 64;
  localparam int PatLenW   = 5;
  localparam int PatBytes  = 16;

  localparam logic [CfgIndexW-1:0] CfgPatLow   = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgPatHigh  = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgPatLen   = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgMatchCase = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgWholeWord = 3'd4;

  localparam int RowOutW = 16;
  localparam int ColOutW = 12;
  localparam int NumOutW = 16;

  typedef struct packed {
    logic [7:0] character;
    logic       line_end;
  } lmf_item_t;

  typedef struct packed {
    logic [PatBytes*8-1:0] pattern;
    logic [PatLenW-1:0]    length;
    logic                  match_case;
    logic                  whole_words;
  } lmf_cfg_t;

  function automatic logic [7:0] fold_char(input logic [7:0] ch, input logic exact);
    logic [7:0] r;
    r = ch;
    if (!exact && ch >= CharUpperA && ch <= CharUpperZ) begin
      r = ch - CharUpperA + CharLowerA;
    end
    return r;
  endfunction

  // ASCII white space and punctuation
  function automatic logic is_boundary(input logic [7:0] ch);
    logic b;
    b = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D) ||
        (ch >= 8'h21 && ch <= 8'h2F) || (ch >= 8'h3A && ch <= 8'h40) ||
        (ch >= 8'h5B && ch <= 8'h60) || (ch >= 8'h7B && ch <= 8'h7E);
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lmf_match.sv
`timescale 1ns / 1ps
`default_nettype none

module lmf_match import lmf_pkg::*; #(
  parameter int PATTERN_MAX = 16,
  parameter int ColW        = 12,
  parameter int HistDepth   = PATTERN_MAX + 1
) (
  input  wire logic [HistDepth-1:0][7:0] hist_i,
  input  wire logic [ColW-1:0]           col_i,
  input  wire lmf_cfg_t                  cfg_i,
  input  wire lmf_item_t                 item_i,
  output logic                           hit_o,
  output logic [ColW-1:0]                first_col_o
);

  localparam int HistIdxW = $clog2(HistDepth);
  localparam int CmpW     = (ColW > PatLenW) ? ColW : PatLenW;

  logic [PatLenW-1:0]     len_eff;
  logic [CmpW-1:0]        col_ext;
  logic [CmpW-1:0]        len_ext;
  logic [PATTERN_MAX-1:0] pos_ok;
  logic [PatLenW-1:0]     off;
  logic                   prev_edge;
  logic [7:0]             prev_ch;
  logic                   bnd_ok;
  logic [CmpW-1:0]        diff;

  always_comb begin
    len_eff = (cfg_i.length > PatLenW'(PATTERN_MAX)) ? PatLenW'(PATTERN_MAX) : cfg_i.length;
    col_ext = CmpW'(col_i);
    len_ext = CmpW'(len_eff);
    for (int k = 0; k < PATTERN_MAX; k++) begin
      off = len_eff - PatLenW'(k) - PatLenW'(1);
      pos_ok[k] = (PatLenW'(k) >= len_eff) ||
                  (fold_char(hist_i[off[HistIdxW-1:0]], cfg_i.match_case) ==
                   fold_char(cfg_i.pattern[k*8 +: 8], cfg_i.match_case));
    end
    prev_edge = !(col_ext > len_ext);
    prev_ch   = hist_i[len_eff[HistIdxW-1:0]];
    bnd_ok    = (prev_edge || is_boundary(prev_ch)) &&
                (item_i.line_end || is_boundary(item_i.character));
    hit_o     = (len_eff != '0) && (col_ext >= len_ext) && (&pos_ok) &&
                (!cfg_i.whole_words || bnd_ok);
    diff        = col_ext - len_ext;
    first_col_o = diff[ColW-1:0];
  end

endmodule

`default_nettype wire

FILE: rtl/core/lmf_state.sv
`timescale 1ns / 1ps
`default_nettype none

module lmf_state import lmf_pkg::*; #(
  parameter int HistDepth = 17,
  parameter int ColW      = 12,
  parameter int RowW      = 16,
  parameter int LINE_MAX  = 4096,
  parameter int ROW_MAX   = 65536
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire lmf_item_t                 item_i,
  input  wire logic                      hit_i,
  output logic [HistDepth-1:0][7:0]      hist_o,
  output logic [ColW-1:0]                col_o,
  output logic [RowW-1:0]                row_o,
  output logic [NumOutW-1:0]             matches_o
);

  localparam logic [ColW-1:0] ColMax = ColW'(LINE_MAX - 1);
  localparam logic [RowW-1:0] RowMax = RowW'(ROW_MAX - 1);

  logic [HistDepth-1:0][7:0] hist_q, hist_d;
  logic [ColW-1:0]           col_q, col_d;
  logic [RowW-1:0]           row_q, row_d;
  logic [NumOutW-1:0]        matches_q, matches_d;

  always_comb begin
    hist_d    = hist_q;
    col_d     = col_q;
    row_d     = row_q;
    matches_d = matches_q;
    if (step_i) begin
      if (hit_i && matches_q != '1) begin
        matches_d = matches_q + NumOutW'(1);
      end
      if (item_i.line_end) begin
        hist_d = '0;
        col_d  = '0;
        if (row_q != RowMax) begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        hist_d = {hist_q[HistDepth-2:0], item_i.character};
        if (col_q != ColMax) begin
          col_d = col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
      matches_q <= '0;
    end else begin
      hist_q    <= hist_d;
      col_q     <= col_d;
      row_q     <= row_d;
      matches_q <= matches_d;
    end
  end

  assign hist_o    = hist_q;
  assign col_o     = col_q;
  assign row_o     = row_q;
  assign matches_o = matches_q;

endmodule

`default_nettype wire

FILE: rtl/core/line_text_match_finder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake             | Payload
// text    | in        | in_valid_i/in_stall_o | character_i, line_end_i
// match   | out       | out_valid_o/out_stall_i | match_row_o, match_column_o, match_number_o
// config  | in        | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One transfer per cycle in each direction while the output is not stalled. An item
// waits in the input register, where the pattern compares and counters are evaluated
// in parallel; a match reaches the output register when the item advances.
// Reset clears history, counters and configuration.
// A stalled output holds the input register, and the input stalls only then.

module line_text_match_finder_core import lmf_pkg::*; #(
  parameter int PATTERN_MAX = 16,
  parameter int LINE_MAX    = 4096,
  parameter int ROW_MAX     = 65536
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           character_i,
  input  wire logic                 line_end_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [RowOutW-1:0]        match_row_o,
  output logic [ColOutW-1:0]        match_column_o,
  output logic [NumOutW-1:0]        match_number_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int HistDepth = PATTERN_MAX + 1;
  localparam int ColW      = $clog2(LINE_MAX);
  localparam int RowW      = $clog2(ROW_MAX);
  localparam int ColExtW   = (ColW > ColOutW) ? ColW : ColOutW;
  localparam int RowExtW   = (RowW > RowOutW) ? RowW : RowOutW;

  lmf_cfg_t  cfg_q;
  logic      s1_valid_q;
  lmf_item_t s1_item_q;
  logic      advance;
  logic      accept;

  logic [HistDepth-1:0][7:0] hist;
  logic [ColW-1:0]           col;
  logic [RowW-1:0]           row;
  logic [NumOutW-1:0]        match_cnt;
  logic                      hit;
  logic [ColW-1:0]           first_col;
  logic [ColExtW-1:0]        first_col_ext;
  logic [RowExtW-1:0]        row_ext;

  logic                      out_valid_q;
  logic [RowOutW-1:0]        row_q;
  logic [ColOutW-1:0]        col_q;
  logic [NumOutW-1:0]        num_q;

  assign advance    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPatLow:    cfg_q.pattern[63:0]   <= cfg_data_i;
        CfgPatHigh:   cfg_q.pattern[127:64] <= cfg_data_i;
        CfgPatLen:    cfg_q.length          <= cfg_data_i[PatLenW-1:0];
        CfgMatchCase: cfg_q.match_case      <= cfg_data_i[0];
        CfgWholeWord: cfg_q.whole_words     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= '{character: character_i, line_end: line_end_i};
    end
  end

  lmf_state #(
    .HistDepth (HistDepth),
    .ColW      (ColW),
    .RowW      (RowW),
    .LINE_MAX  (LINE_MAX),
    .ROW_MAX   (ROW_MAX)
  ) u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (s1_item_q),
    .hit_i     (hit),
    .hist_o    (hist),
    .col_o     (col),
    .row_o     (row),
    .matches_o (match_cnt)
  );

  lmf_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .ColW        (ColW),
    .HistDepth   (HistDepth)
  ) u_match (
    .hist_i      (hist),
    .col_i       (col),
    .cfg_i       (cfg_q),
    .item_i      (s1_item_q),
    .hit_o       (hit),
    .first_col_o (first_col)
  );

  assign first_col_ext = ColExtW'(first_col);
  assign row_ext       = RowExtW'(row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= hit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && hit) begin
      row_q <= row_ext[RowOutW-1:0];
      col_q <= first_col_ext[ColOutW-1:0];
      num_q <= match_cnt;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_row_o    = row_q;
  assign match_column_o = col_q;
  assign match_number_o = num_q;

endmodule

`default_nettype wire

FILE: verif/lmf_match_checker.sv
`timescale 1ns / 1ps

module lmf_match_checker import lmf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [7:0]           character_i,
  input  logic                 line_end_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [RowOutW-1:0]   match_row_i,
  input  logic [ColOutW-1:0]   match_column_i,
  input  logic [NumOutW-1:0]   match_number_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output int                   error_count_o,
  output int                   pending_count_o,
  output int                   checked_count_o
);

  localparam int HistDepth = 18;
  localparam int PatMax    = 16;
  localparam int LineLast  = 4095;
  localparam int RowLast   = 65535;
  localparam int NumLast   = 65535;

  typedef struct packed {
    logic [RowOutW-1:0] row;
    logic [ColOutW-1:0] col;
    logic [NumOutW-1:0] num;
  } match_pos_t;

  match_pos_t expected_matches[$];

  logic [PatBytes*8-1:0] pat_bytes;
  logic [PatLenW-1:0]    pat_len;
  logic                  exact_case;
  logic                  whole_words;
  logic [7:0]            history [0:HistDepth-1];
  int unsigned           col_cnt;
  int unsigned           row_cnt;
  int unsigned           seen_cnt;
  int                    n_errors;
  int                    n_pending;
  int                    n_checked;

  assign error_count_o   = n_errors;
  assign pending_count_o = n_pending;
  assign checked_count_o = n_checked;

  initial begin
    pat_bytes   = '0;
    pat_len     = '0;
    exact_case  = 1'b0;
    whole_words = 1'b0;
    for (int i = 0; i < HistDepth; i++) history[i] = 8'h00;
    col_cnt   = 0;
    row_cnt   = 0;
    seen_cnt  = 0;
    n_errors  = 0;
    n_pending = 0;
    n_checked = 0;
  end

  function automatic logic [7:0] fold_ascii(input logic [7:0] ch, input logic exact);
    if (!exact && ch inside {[CharUpperA:CharUpperZ]}) begin
      return ch + (CharLowerA - CharUpperA);
    end
    return ch;
  endfunction

  // white space or punctuation
  function automatic bit word_gap(input logic [7:0] ch);
    return ch inside {8'h20, [8'h09:8'h0D], [8'h21:8'h2F], [8'h3A:8'h40],
                      [8'h5B:8'h60], [8'h7B:8'h7E]};
  endfunction

  // a match ending at the newest stored char is decided by the incoming item
  task automatic scan_text_item(input logic [7:0] ch, input logic le);
    int         len;
    bit         hit;
    match_pos_t m;
    len = (pat_len > PatMax) ? PatMax : int'(pat_len);
    hit = (len != 0) && (col_cnt >= len);
    for (int k = 0; k < len; k++) begin
      if (fold_ascii(history[len-1-k], exact_case) !=
          fold_ascii(pat_bytes[k*8 +: 8], exact_case)) begin
        hit = 0;
      end
    end
    if (hit && whole_words) begin
      if (col_cnt > len && !word_gap(history[len])) hit = 0;
      if (!le && !word_gap(ch)) hit = 0;
    end
    if (hit) begin
      m.row = row_cnt[RowOutW-1:0];
      m.col = ColOutW'(col_cnt - len);
      m.num = seen_cnt[NumOutW-1:0];
      expected_matches.push_back(m);
      if (seen_cnt < NumLast) seen_cnt++;
    end
    if (le) begin
      for (int i = 0; i < HistDepth; i++) history[i] = 8'h00;
      col_cnt = 0;
      if (row_cnt < RowLast) row_cnt++;
    end else begin
      for (int i = HistDepth - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = ch;
      if (col_cnt < LineLast) col_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    match_pos_t want;
    match_pos_t got;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got = {match_row_i, match_column_i, match_number_i};
        if (expected_matches.size() == 0) begin
          $display("%0t: unexpected match: got row %0d column %0d number %0d",
                   $time, got.row, got.col, got.num);
          n_errors++;
        end else begin
          want = expected_matches.pop_front();
          n_checked++;
          if (got !== want) begin
            $display("%0t: match mismatch: expected row %0d column %0d number %0d, got row %0d column %0d number %0d",
                     $time, want.row, want.col, want.num, got.row, got.col, got.num);
            n_errors++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgPatLow:    pat_bytes[63:0]   = cfg_data_i;
          CfgPatHigh:   pat_bytes[127:64] = cfg_data_i;
          CfgPatLen:    pat_len           = cfg_data_i[PatLenW-1:0];
          CfgMatchCase: exact_case        = cfg_data_i[0];
          CfgWholeWord: whole_words       = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) scan_text_item(character_i, line_end_i);
      n_pending = expected_matches.size();
    end
  end

endmodule

FILE: verif/line_text_match_finder_core_tb.sv
`timescale 1ns / 1ps

module line_text_match_finder_core_tb;
  import lmf_pkg::*;

  localparam logic [CfgIndexW-1:0] CfgSpareFirst = 3'd5;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           character_i;
  logic                 line_end_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [RowOutW-1:0]   match_row_o;
  logic [ColOutW-1:0]   match_column_o;
  logic [NumOutW-1:0]   match_number_o;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  int error_count;
  int pending_count;
  int checked_count;

  int hold_request = 0;
  int burst_left = 0;
  int items_sent = 0;
  int regs_written = 0;
  logic [7:0] cur_pat [0:15];
  int cur_len = 0;

  line_text_match_finder_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .character_i    (character_i),
    .line_end_i     (line_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_row_o    (match_row_o),
    .match_column_o (match_column_o),
    .match_number_o (match_number_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  lmf_match_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .character_i     (character_i),
    .line_end_i      (line_end_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .match_row_i     (match_row_o),
    .match_column_i  (match_column_o),
    .match_number_i  (match_number_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .error_count_o   (error_count),
    .pending_count_o (pending_count),
    .checked_count_o (checked_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d matches outstanding", pending_count);
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stall segments, plus a long hold-off on request
  initial begin : receiver
    int mode;
    int seg_left;
    int hold_left;
    mode = 0;
    seg_left = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(5, 80);
        end
        seg_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic logic [7:0] gap_char();
    case ($urandom_range(0, 13))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0D;
      5: return 8'h21;
      6: return 8'h2F;
      7: return 8'h3A;
      8: return 8'h40;
      9: return 8'h5B;
      10: return 8'h60;
      11: return 8'h7B;
      12: return 8'h7E;
      default: return 8'h2C;
    endcase
  endfunction

  // word characters just outside the boundary ranges
  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 13))
      0: return 8'h00;
      1: return 8'h08;
      2: return 8'h0E;
      3: return 8'h1F;
      4: return 8'h30;
      5: return 8'h39;
      6: return 8'h41;
      7: return 8'h5A;
      8: return 8'h61;
      9: return 8'h7A;
      10: return 8'h7F;
      11: return 8'h80;
      12: return 8'hC1;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [127:0] random_pattern();
    logic [127:0] p;
    int r;
    for (int k = 0; k < 16; k++) begin
      r = $urandom_range(0, 9);
      if (r < 6) p[k*8 +: 8] = (r[0] ? 8'h62 : CharLowerA) ^ (r[1] ? 8'h20 : 8'h00);
      else if (r < 8) p[k*8 +: 8] = gap_char();
      else p[k*8 +: 8] = 8'($urandom_range(0, 255));
    end
    return p;
  endfunction

  function automatic int random_length();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 16;
      2: return $urandom_range(17, 31);
      3: return $urandom_range(5, 15);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  function automatic logic [63:0] upper_noise();
    if ($urandom_range(0, 2) == 0) return {$urandom, $urandom};
    return '0;
  endfunction

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    regs_written++;
  endtask

  task automatic set_pattern(input logic [127:0] bytes, input int len_val, input logic exact,
                             input logic whole);
    logic [63:0] word;
    for (int k = 0; k < 16; k++) cur_pat[k] = bytes[k*8 +: 8];
    cur_len = (len_val > 16) ? 16 : len_val;
    write_reg(CfgPatLow, bytes[63:0]);
    write_reg(CfgPatHigh, bytes[127:64]);
    word = upper_noise();
    word[PatLenW-1:0] = len_val[PatLenW-1:0];
    write_reg(CfgPatLen, word);
    word = upper_noise();
    word[0] = exact;
    write_reg(CfgMatchCase, word);
    word = upper_noise();
    word[0] = whole;
    write_reg(CfgWholeWord, word);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CfgSpareFirst + CfgIndexW'($urandom_range(0, 2)), {$urandom, $urandom});
    end
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i  <= 1'b0;
      character_i <= 8'($urandom);
      line_end_i  <= 1'($urandom);
    end
  endtask

  task automatic send_item(input logic [7:0] ch, input logic le);
    if (burst_left == 0) begin
      idle_for(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    character_i <= ch;
    line_end_i  <= le;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // wait for all outstanding matches, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // pattern copies with case flips, near misses, boundaries and noise
  task automatic gen_text(input int count, input bit allow_le);
    int left;
    int pick;
    int n;
    logic [7:0] b;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 && cur_len > 0) begin
        for (int k = 0; k < cur_len; k++) begin
          b = cur_pat[k];
          if ((b | 8'h20) inside {[8'h61:8'h7A]} && $urandom_range(0, 1)) b = b ^ 8'h20;
          send_item(b, 1'b0);
        end
        left -= cur_len;
      end else if (pick < 45 && cur_len > 1) begin
        n = $urandom_range(1, cur_len - 1);
        for (int k = 0; k < n; k++) send_item(cur_pat[k], 1'b0);
        left -= n;
      end else if (pick < 65) begin
        send_item(gap_char(), 1'b0);
        left--;
      end else if (pick < 75) begin
        send_item(odd_char(), 1'b0);
        left--;
      end else if (pick < 82 && cur_len > 0) begin
        send_item(cur_pat[$urandom_range(0, cur_len - 1)], 1'b0);
        left--;
      end else if (pick < 90 || !allow_le) begin
        send_item(8'($urandom_range(0, 255)), 1'b0);
        left--;
      end else begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
        left--;
      end
    end
  endtask

  initial begin : stimulus
    int wait_left;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    character_i = 8'h00;
    line_end_i  = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // matching disabled after reset
    send_item(CharLowerA, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);

    // folded whole-word search for "Ab"
    drain();
    set_pattern(128'h6241, 2, 1'b0, 1'b1);
    send_item(CharLowerA, 1'b0);
    send_item(8'h42, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h20, 1'b0);
    send_item(CharUpperA, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h2E, 1'b0);
    send_item(8'h78, 1'b0);
    send_item(CharLowerA, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(CharLowerA, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b1);

    // exact case, no word check
    drain();
    set_pattern(128'h6241, 2, 1'b1, 1'b0);
    send_item(CharLowerA, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(CharUpperA, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h20, 1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: set_pattern({128{1'b1}}, 16, 1'b1, 1'b0);
        1: set_pattern('0, 31, 1'b0, 1'b1);
        2: set_pattern(random_pattern(), 31, 1'b0, 1'b0);
        3: set_pattern(random_pattern(), 0, 1'b1, 1'b1);
        default: set_pattern(random_pattern(), random_length(), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
      endcase
      gen_text(70, 1'b1);
    end

    // long receiver hold-off while text keeps coming
    drain();
    set_pattern(128'h61, 1, 1'b0, 1'b0);
    @(posedge clk_i);
    hold_request = 400;
    repeat (200) send_item($urandom_range(0, 1) ? CharLowerA : CharUpperA, 1'b0);
    send_item(8'h20, 1'b1);

    drain();
    set_pattern(random_pattern(), $urandom_range(1, 3), 1'($urandom_range(0, 1)), 1'b0);
    gen_text(100, 1'b1);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_left = 20000;
    while (pending_count != 0 && wait_left > 0) begin
      @(negedge clk_i);
      wait_left--;
    end
    repeat (10) @(negedge clk_i);

    $display("Sent %0d text items with %0d register writes, %0d matches compared.",
             items_sent, regs_written, checked_count);
    $display("Covered pattern lengths 0 to 31, both case modes, word check and a full pipe.");
    if (pending_count != 0) begin
      $display("%0t: %0d expected matches never arrived", $time, pending_count);
    end
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
